>>> sv/gwp_pkg.sv
package gwp_pkg;

    // Number format
    localparam int FRAC_DIGITS = 3;
    localparam int VALUE_BITS  = 32;
    localparam int ACC_W       = 37;

    // Code fields
    localparam logic [9:0] NO_CODE  = 10'd1023;
    localparam logic [9:0] CODE_MAX = 10'd1022;

    // Line status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_COMMENT = 2'd1;
    localparam logic [1:0] STAT_ERROR   = 2'd2;

    // Characters
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_PAREN  = 8'h28;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_Z      = 8'h5A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Word letters, offset from 'A'
    localparam logic [4:0] LTR_F = 5'd5;
    localparam logic [4:0] LTR_G = 5'd6;
    localparam logic [4:0] LTR_I = 5'd8;
    localparam logic [4:0] LTR_J = 5'd9;
    localparam logic [4:0] LTR_K = 5'd10;
    localparam logic [4:0] LTR_M = 5'd12;
    localparam logic [4:0] LTR_R = 5'd17;
    localparam logic [4:0] LTR_S = 5'd18;
    localparam logic [4:0] LTR_X = 5'd23;
    localparam logic [4:0] LTR_Y = 5'd24;
    localparam logic [4:0] LTR_Z = 5'd25;

    // Held value slots
    localparam int NUM_HELD = 9;

    // Powers of ten up to the largest fraction scale
    function automatic logic [23:0] pow10(input logic [2:0] n);
        logic [23:0] p;
        unique case (n)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            default: p = 24'd0;
        endcase
        return p;
    endfunction

    localparam logic [23:0] UNIT_SCALE = pow10(3'(FRAC_DIGITS));

    // Saturation limit of a magnitude
    localparam logic [31:0] MAG_CAP = (VALUE_BITS >= 32) ? 32'h7FFF_FFFF :
        32'((64'd1 << (VALUE_BITS - 1)) - 64'd1);

    // Whole part of a saturated magnitude, clipped to 1023
    localparam logic [31:0] CAP_WHOLE_FULL = MAG_CAP / 32'(UNIT_SCALE);
    localparam logic [10:0] CAP_WHOLE = (CAP_WHOLE_FULL > 32'd1023) ? 11'd1023 :
        11'(CAP_WHOLE_FULL);

    typedef struct packed {
        logic [7:0] char_in;
        logic       line_end;
    } gwp_in_t;

    typedef struct packed {
        logic [9:0]         g_code;
        logic [9:0]         m_code;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] arc_i;
        logic signed [31:0] arc_j;
        logic signed [31:0] arc_k;
        logic signed [31:0] spindle_speed;
        logic signed [31:0] feed_rate;
        logic signed [31:0] arc_radius;
        logic [1:0]         line_status;
    } gwp_out_t;

endpackage

>>> sv/gcode_word_parser.sv
// G-code word parser. One character of a line is taken per transfer on the s_
// channel, with line_end set on the last character; one result per line comes
// out on the m_ channel after that character. The block takes a character in
// every cycle unless a result waits: each passes through a single register
// stage (multiply by ten, add and saturate on the value accumulator), and the
// result register frees the input side whenever it is empty or being taken. A
// result waiting for m_ready holds off every input transfer until it is taken.
// Values are decimal fixed point scaled by 10^FRAC_DIGITS; X Y Z I J K S F R
// values are held across lines, while G and M codes, status and word state
// clear at each line end.
module gcode_word_parser
    import gwp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  gwp_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output gwp_out_t m_data
);

    typedef enum logic [6:0] {
        PH_LEAD    = 7'b0000001,
        PH_GAP     = 7'b0000010,
        PH_SIGN    = 7'b0000100,
        PH_INT     = 7'b0001000,
        PH_FRAC    = 7'b0010000,
        PH_COMMENT = 7'b0100000,
        PH_ERROR   = 7'b1000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  letter_reg, letter_next;
    logic        neg_reg, neg_next;
    logic [31:0] mag_reg, mag_next;
    logic [2:0]  frac_cnt_reg, frac_cnt_next;
    logic [10:0] whole_reg, whole_next;
    logic [9:0]  line_g_reg, line_g_next;
    logic [9:0]  line_m_reg, line_m_next;
    logic [31:0] held_reg [NUM_HELD];
    logic [31:0] held_next [NUM_HELD];
    logic        err_reg, err_next;
    logic        cmt_reg, cmt_next;
    logic        m_valid_reg;
    gwp_out_t    m_data_reg, m_data_next;

    logic        s_fire;
    logic [7:0]  ch;
    logic        is_blank, is_digit, is_letter;
    logic [3:0]  digit;
    logic [ACC_W-1:0] int_sum, frac_sum;
    logic [14:0] whole_sum;
    logic [2:0]  frac_idx;
    logic        do_commit, commit_now;
    logic [31:0] signed_val;
    logic [9:0]  code_val;
    logic [1:0]  status;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Classify the incoming character
    assign ch        = s_data.char_in;
    assign is_blank  = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_letter = (ch >= CH_A) && (ch <= CH_Z);
    assign digit     = 4'(ch - CH_ZERO);
    assign frac_idx  = 3'(FRAC_DIGITS - 1 - int'(frac_cnt_reg));

    // Accumulate: integer digit scales by ten, fraction digit adds its weight
    assign int_sum = ({5'd0, mag_reg} << 3) + ({5'd0, mag_reg} << 1)
                   + ACC_W'(digit * UNIT_SCALE);
    assign frac_sum  = {5'd0, mag_reg} + ACC_W'(digit * pow10(frac_idx));
    assign whole_sum = ({4'd0, whole_reg} << 3) + ({4'd0, whole_reg} << 1)
                     + 15'(digit);

    // Advance the parse state by one character, then close an open word
    always_comb begin
        phase_next    = phase_reg;
        letter_next   = letter_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        frac_cnt_next = frac_cnt_reg;
        whole_next    = whole_reg;
        line_g_next   = line_g_reg;
        line_m_next   = line_m_reg;
        err_next      = err_reg;
        cmt_next      = cmt_reg;
        do_commit     = 1'b0;
        for (int i = 0; i < NUM_HELD; i++) begin
            held_next[i] = held_reg[i];
        end

        unique case (phase_reg)
            PH_LEAD, PH_GAP: begin
                if (is_blank) begin
                    phase_next = phase_reg;
                end else if (phase_reg == PH_LEAD && (ch == CH_SEMI || ch == CH_PAREN)) begin
                    cmt_next   = 1'b1;
                    phase_next = PH_COMMENT;
                end else if (is_letter) begin
                    letter_next   = 5'(ch - CH_A);
                    neg_next      = 1'b0;
                    mag_next      = '0;
                    frac_cnt_next = '0;
                    whole_next    = '0;
                    phase_next    = PH_SIGN;
                end else begin
                    err_next   = 1'b1;
                    phase_next = PH_ERROR;
                end
            end
            PH_SIGN, PH_INT: begin
                if (phase_reg == PH_SIGN && (ch == CH_MINUS || ch == CH_PLUS)) begin
                    neg_next   = (ch == CH_MINUS);
                    phase_next = PH_INT;
                end else if (is_blank) begin
                    do_commit = 1'b1;
                end else if (ch == CH_POINT) begin
                    phase_next = PH_FRAC;
                end else if (is_digit) begin
                    if (int_sum > ACC_W'(MAG_CAP)) begin
                        mag_next   = MAG_CAP;
                        whole_next = CAP_WHOLE;
                    end else begin
                        mag_next   = int_sum[31:0];
                        whole_next = (whole_sum > 15'd1023) ? 11'd1023 : whole_sum[10:0];
                    end
                    phase_next = PH_INT;
                end else begin
                    err_next   = 1'b1;
                    phase_next = PH_ERROR;
                end
            end
            PH_FRAC: begin
                if (is_blank) begin
                    do_commit = 1'b1;
                end else if (is_digit) begin
                    if (int'(frac_cnt_reg) < FRAC_DIGITS) begin
                        if (frac_sum > ACC_W'(MAG_CAP)) begin
                            mag_next   = MAG_CAP;
                            whole_next = CAP_WHOLE;
                        end else begin
                            mag_next = frac_sum[31:0];
                        end
                        frac_cnt_next = frac_cnt_reg + 3'd1;
                    end
                end else begin
                    err_next   = 1'b1;
                    phase_next = PH_ERROR;
                end
            end
            PH_COMMENT, PH_ERROR: begin
                phase_next = phase_reg;
            end
            default: begin
                phase_next = PH_ERROR;
            end
        endcase

        // Close the word on a blank or at the end of the line
        commit_now = do_commit || (s_data.line_end &&
            (phase_next == PH_SIGN || phase_next == PH_INT || phase_next == PH_FRAC));
        signed_val = neg_next ? 32'(32'd0 - mag_next) : mag_next;
        code_val   = (whole_next > 11'(CODE_MAX)) ? CODE_MAX : whole_next[9:0];
        if (commit_now) begin
            phase_next = PH_GAP;
            unique case (letter_next)
                LTR_G, LTR_M: begin
                    if (neg_next) begin
                        err_next   = 1'b1;
                        phase_next = PH_ERROR;
                    end else if (letter_next == LTR_G) begin
                        line_g_next = code_val;
                    end else begin
                        line_m_next = code_val;
                    end
                end
                LTR_X:   held_next[0] = signed_val;
                LTR_Y:   held_next[1] = signed_val;
                LTR_Z:   held_next[2] = signed_val;
                LTR_I:   held_next[3] = signed_val;
                LTR_J:   held_next[4] = signed_val;
                LTR_K:   held_next[5] = signed_val;
                LTR_S:   held_next[6] = signed_val;
                LTR_F:   held_next[7] = signed_val;
                LTR_R:   held_next[8] = signed_val;
                default: held_next[0] = held_reg[0];
            endcase
        end
    end

    // Build the line result from the post-character state
    always_comb begin
        status = cmt_next ? STAT_COMMENT : (err_next ? STAT_ERROR : STAT_OK);
        m_data_next.g_code        = (status != STAT_OK) ? NO_CODE : line_g_next;
        m_data_next.m_code        = (status != STAT_OK) ? NO_CODE : line_m_next;
        m_data_next.pos_x         = $signed(held_next[0]);
        m_data_next.pos_y         = $signed(held_next[1]);
        m_data_next.pos_z         = $signed(held_next[2]);
        m_data_next.arc_i         = $signed(held_next[3]);
        m_data_next.arc_j         = $signed(held_next[4]);
        m_data_next.arc_k         = $signed(held_next[5]);
        m_data_next.spindle_speed = $signed(held_next[6]);
        m_data_next.feed_rate     = $signed(held_next[7]);
        m_data_next.arc_radius    = $signed(held_next[8]);
        m_data_next.line_status   = status;
    end

    // Hold parse and line state; clear the line state at each line end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_LEAD;
            letter_reg   <= '0;
            neg_reg      <= 1'b0;
            mag_reg      <= '0;
            frac_cnt_reg <= '0;
            whole_reg    <= '0;
            line_g_reg   <= NO_CODE;
            line_m_reg   <= NO_CODE;
            err_reg      <= 1'b0;
            cmt_reg      <= 1'b0;
            for (int i = 0; i < NUM_HELD; i++) begin
                held_reg[i] <= '0;
            end
        end else if (s_fire) begin
            for (int i = 0; i < NUM_HELD; i++) begin
                held_reg[i] <= held_next[i];
            end
            if (s_data.line_end) begin
                phase_reg    <= PH_LEAD;
                letter_reg   <= '0;
                neg_reg      <= 1'b0;
                mag_reg      <= '0;
                frac_cnt_reg <= '0;
                whole_reg    <= '0;
                line_g_reg   <= NO_CODE;
                line_m_reg   <= NO_CODE;
                err_reg      <= 1'b0;
                cmt_reg      <= 1'b0;
            end else begin
                phase_reg    <= phase_next;
                letter_reg   <= letter_next;
                neg_reg      <= neg_next;
                mag_reg      <= mag_next;
                frac_cnt_reg <= frac_cnt_next;
                whole_reg    <= whole_next;
                line_g_reg   <= line_g_next;
                line_m_reg   <= line_m_next;
                err_reg      <= err_next;
                cmt_reg      <= cmt_next;
            end
        end
    end

    // Result register: load at a line end, drop after the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire && s_data.line_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_data.line_end) begin
            m_data_reg <= m_data_next;
        end
    end

`ifndef SYNTHESIS
    a_line_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_data.line_end |=> m_valid_reg)
        else $error("line end did not produce a result");

    a_line_end_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_data.line_end |=> phase_reg == PH_LEAD && !err_reg && !cmt_reg)
        else $error("line state not cleared after line end");

    a_no_codes_on_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.line_status != STAT_OK |->
            m_data_reg.g_code == NO_CODE && m_data_reg.m_code == NO_CODE)
        else $error("codes reported on a comment or error line");

    a_frac_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(frac_cnt_reg) <= FRAC_DIGITS && mag_reg <= MAG_CAP)
        else $error("fraction count or magnitude out of range");
`endif

endmodule
